@@ rtl/core/mpcz_pkg.sv @@
// ----------------------------------------------------------------------------
// mpcz_pkg
// shared types, constants and helpers for the pixel color zone lookup core
// ----------------------------------------------------------------------------
`default_nettype none
package mpcz_pkg;

   localparam int MAX_WIDTH_DEF       = 256;
   localparam int MAX_HEIGHT_DEF      = 256;
   localparam int MAX_HALF_WINDOW_DEF = 16;

   localparam logic [1:0] ZONE_GREEN     = 2'd0;
   localparam logic [1:0] ZONE_YELLOW    = 2'd1;
   localparam logic [1:0] ZONE_RED       = 2'd2;
   localparam logic [1:0] ZONE_NOT_VALID = 2'd3;

   localparam logic [2:0] CSR_TOLERANCE = 3'd0;
   localparam logic [2:0] CSR_SCALE     = 3'd1;
   localparam logic [2:0] CSR_CENTER_X  = 3'd2;
   localparam logic [2:0] CSR_CENTER_Y  = 3'd3;
   localparam logic [2:0] CSR_WIDTH     = 3'd4;
   localparam logic [2:0] CSR_HEIGHT    = 3'd5;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic               op;
      logic [15:0]        pixel_index;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
   } req_type;

   typedef struct packed {
      logic [1:0] zone;
      logic       from_window;
   } rsp_type;

   // class result: hit flag and zone code
   typedef struct packed {
      logic       hit;
      logic [1:0] zone;
   } class_type;

   function automatic logic [16:0] sq_diff(input logic [7:0] a, input logic [7:0] b);
      logic [7:0]  d;
      logic [15:0] sq;
      d  = (a > b) ? (a - b) : (b - a);
      sq = 16'(d) * 16'(d);
      return {1'b0, sq};
   endfunction

   // priority test against red, yellow, green, white
   function automatic class_type classify(input logic [23:0] pix, input logic [17:0] tol2);
      logic [18:0] d_red, d_yel, d_grn, d_wht;
      class_type   c;
      d_red = 19'(sq_diff(pix[23:16], 8'd255)) + 19'(sq_diff(pix[15:8], 8'd0))
            + 19'(sq_diff(pix[7:0], 8'd0));
      d_yel = 19'(sq_diff(pix[23:16], 8'd255)) + 19'(sq_diff(pix[15:8], 8'd255))
            + 19'(sq_diff(pix[7:0], 8'd0));
      d_grn = 19'(sq_diff(pix[23:16], 8'd0)) + 19'(sq_diff(pix[15:8], 8'd166))
            + 19'(sq_diff(pix[7:0], 8'd80));
      d_wht = 19'(sq_diff(pix[23:16], 8'd255)) + 19'(sq_diff(pix[15:8], 8'd255))
            + 19'(sq_diff(pix[7:0], 8'd255));
      c.hit  = 1'b1;
      c.zone = ZONE_NOT_VALID;
      if (d_red < {1'b0, tol2}) begin
         c.zone = ZONE_RED;
      end else if (d_yel < {1'b0, tol2}) begin
         c.zone = ZONE_YELLOW;
      end else if (d_grn < {1'b0, tol2}) begin
         c.zone = ZONE_GREEN;
      end else if (d_wht < {1'b0, tol2}) begin
         c.zone = ZONE_NOT_VALID;
      end else begin
         c.hit = 1'b0;
      end
      return c;
   endfunction

endpackage
`default_nettype wire

@@ rtl/core/mpcz_store.sv @@
// ----------------------------------------------------------------------------
// mpcz_store
// image store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module mpcz_store #(
   parameter int DEPTH = mpcz_pkg::MAX_WIDTH_DEF * mpcz_pkg::MAX_HEIGHT_DEF,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [23:0]   wr_data,
   input  wire logic [AW-1:0] rd_addr,
   output logic [23:0]        rd_data
);

   logic [23:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

@@ rtl/core/map_pixel_color_zone_lookup_core.sv @@
// steps: a pixel write goes to the store while idle; a query runs MULX, MULY, READ,
//   then OUT off the image, else CTR; on a center miss with h > 0, WADR and WCLS per
//   window pixel (4*h*h) follow, then OUT; h = min(10*scale >> 12, MAX_HALF_WINDOW)
// throughput: one item at a time; a held result stalls the next one
// reset: synchronous active high; state and CSRs to defaults, image store undefined
// ----------------------------------------------------------------------------
// map_pixel_color_zone_lookup_core
// maps a position to a pixel, classifies it, falls back to a window vote
// ----------------------------------------------------------------------------
`default_nettype none
module map_pixel_color_zone_lookup_core #(
   parameter int MAX_WIDTH       = mpcz_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT      = mpcz_pkg::MAX_HEIGHT_DEF,
   parameter int MAX_HALF_WINDOW = mpcz_pkg::MAX_HALF_WINDOW_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mpcz_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mpcz_pkg::rsp_type     rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [2:0]       csr_index,
   input  wire logic [15:0]      csr_wdata
);

   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = 14;  // coordinate width, covers 4096 + 2*64
   localparam int HW    = $clog2(MAX_HALF_WINDOW + 1);
   localparam int NW    = 2 * HW + 3;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MULX = 3'd1;
   localparam logic [2:0] ST_MULY = 3'd2;
   localparam logic [2:0] ST_READ = 3'd3;
   localparam logic [2:0] ST_CTR  = 3'd4;
   localparam logic [2:0] ST_WADR = 3'd5;
   localparam logic [2:0] ST_WCLS = 3'd6;
   localparam logic [2:0] ST_OUT  = 3'd7;

   logic [2:0]  state_ff, state_in;
   logic [8:0]  tol_ff;
   logic [15:0] scale_ff;
   logic [7:0]  cx_ff, cy_ff;
   logic [8:0]  wreg_ff, hreg_ff;
   mpcz_pkg::req_type req_ff;
   logic signed [CW-1:0] px_ff, py_ff, wx_ff, wy_ff;
   logic        bad_ff;
   logic [HW-1:0] h_ff;
   logic [NW-1:0] cnt_ff [4];
   logic        rsp_valid_ff;
   mpcz_pkg::rsp_type rsp_ff;
   mpcz_pkg::rsp_type work_ff;

   // shared multiplier: pos*scale or row*width
   logic signed [19:0] mul_a;
   logic signed [16:0] mul_b;
   logic signed [37:0] mul_p;
   logic signed [37:0] t;
   logic [AW-1:0] rd_addr;
   logic [23:0]   rd_data;
   logic [12:0]   weff, heff;
   mpcz_pkg::class_type cls;
   logic [19:0]   h10;
   logic [HW-1:0] h_sat;
   logic          wx_in_range, wy_last, wx_last;
   logic          rsp_hold;
   logic [1:0]    vote_zone;

   assign weff = (13'(wreg_ff) > 13'(MAX_WIDTH))  ? 13'(MAX_WIDTH)  : 13'(wreg_ff);
   assign heff = (13'(hreg_ff) > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : 13'(hreg_ff);
   assign cls  = mpcz_pkg::classify(rd_data, 18'(tol_ff) * 18'(tol_ff));
   assign h10  = 20'(scale_ff) * 20'd10;
   assign h_sat = (h10[19:12] > 8'(MAX_HALF_WINDOW)) ? HW'(MAX_HALF_WINDOW) : HW'(h10[19:12]);

   always_comb begin
      mul_a = req_ff.pos_x;
      mul_b = 17'(scale_ff);
      case (state_ff)
         ST_MULY: begin
            mul_a = req_ff.pos_y;
         end
         ST_WADR: begin
            mul_a = 20'(wy_ff);
            mul_b = 17'(weff);
         end
         ST_MULX: begin
            mul_a = req_ff.pos_x;
         end
         default: begin
            mul_a = 20'(py_ff);
            mul_b = 17'(weff);
         end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   assign wx_in_range = (wx_ff >= 0) && (wx_ff < $signed({1'b0, weff}));
   assign wx_last = (wx_ff == px_ff + $signed(CW'(h_ff)) - 1);
   assign wy_last = (wy_ff == py_ff + $signed(CW'(h_ff)) - 1);

   mpcz_store #(.DEPTH(DEPTH)) u_store (
      .clock  (clock),
      .wr_en  (state_ff == ST_IDLE && req_valid && req_data.op == mpcz_pkg::OP_WRITE
               && 32'(req_data.pixel_index) < DEPTH),
      .wr_addr(AW'(req_data.pixel_index)),
      .wr_data({req_data.red, req_data.green, req_data.blue}),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      rd_addr = AW'(mul_p + 38'(state_ff == ST_READ ? px_ff : wx_ff));
   end

   assign rsp_hold  = rsp_valid_ff && rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff   <= 9'd50;
         scale_ff <= '0;
         cx_ff    <= '0;
         cy_ff    <= '0;
         wreg_ff  <= 9'd256;
         hreg_ff  <= 9'd256;
      end else if (csr_valid) begin
         case (csr_index)
            mpcz_pkg::CSR_TOLERANCE: tol_ff   <= csr_wdata[8:0];
            mpcz_pkg::CSR_SCALE:     scale_ff <= csr_wdata;
            mpcz_pkg::CSR_CENTER_X:  cx_ff    <= csr_wdata[7:0];
            mpcz_pkg::CSR_CENTER_Y:  cy_ff    <= csr_wdata[7:0];
            mpcz_pkg::CSR_WIDTH:     wreg_ff  <= csr_wdata[8:0];
            mpcz_pkg::CSR_HEIGHT:    hreg_ff  <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      t = mul_p + $signed({1'b0, (state_ff == ST_MULX ? cx_ff : cy_ff), 16'd0});
   end

   // majority vote, lowest zone code wins a tie
   always_comb begin
      if (cnt_ff[0] != '0 && cnt_ff[0] >= cnt_ff[1] && cnt_ff[0] >= cnt_ff[2]
          && cnt_ff[0] >= cnt_ff[3]) begin
         vote_zone = mpcz_pkg::ZONE_GREEN;
      end else if (cnt_ff[1] != '0 && cnt_ff[1] >= cnt_ff[2]
                   && cnt_ff[1] >= cnt_ff[3]) begin
         vote_zone = mpcz_pkg::ZONE_YELLOW;
      end else if (cnt_ff[2] != '0 && cnt_ff[2] >= cnt_ff[3]) begin
         vote_zone = mpcz_pkg::ZONE_RED;
      end else begin
         vote_zone = mpcz_pkg::ZONE_NOT_VALID;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid && !req_stall && req_data.op == mpcz_pkg::OP_QUERY) begin
            state_in = ST_MULX;
         end
         ST_MULX: state_in = ST_MULY;
         ST_MULY: state_in = ST_READ;
         ST_READ: state_in = bad_ff ? ST_OUT : ST_CTR;
         ST_CTR:  state_in = (cls.hit || h_ff == '0) ? ST_OUT : ST_WADR;
         ST_WADR: state_in = ST_WCLS;
         ST_WCLS: state_in = (wx_last && wy_last) ? ST_OUT : ST_WADR;
         ST_OUT:  state_in = rsp_hold ? ST_OUT : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_OUT && !rsp_hold) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            req_ff  <= req_data;
            bad_ff  <= 1'b0;
            h_ff    <= h_sat;
            work_ff <= '{zone: mpcz_pkg::ZONE_NOT_VALID, from_window: 1'b0};
            for (int k = 0; k < 4; k++) cnt_ff[k] <= '0;
         end
         ST_MULX: begin
            px_ff <= CW'(t >>> 16);
            if (t < 0 || (t >>> 16) >= 38'(weff)) bad_ff <= 1'b1;
         end
         ST_MULY: begin
            py_ff <= CW'(t >>> 16);
            if (t < 0 || (t >>> 16) >= 38'(heff)) bad_ff <= 1'b1;
         end
         ST_READ: begin
            wx_ff <= px_ff - $signed(CW'(h_ff));
            wy_ff <= py_ff - $signed(CW'(h_ff));
         end
         ST_CTR: begin
            if (cls.hit) begin
               work_ff.zone <= cls.zone;
            end else begin
               work_ff.from_window <= 1'b1;
            end
         end
         ST_WADR: begin
         end
         ST_WCLS: begin
            if (wx_in_range && wy_ff >= 0 && wy_ff < $signed({1'b0, heff}) && cls.hit) begin
               cnt_ff[cls.zone] <= cnt_ff[cls.zone] + 1'b1;
            end
            if (wy_last) begin
               wy_ff <= py_ff - $signed(CW'(h_ff));
               wx_ff <= wx_ff + 1;
            end else begin
               wy_ff <= wy_ff + 1;
            end
         end
         ST_OUT: begin
            if (!rsp_hold) begin
               rsp_ff.zone        <= work_ff.from_window ? vote_zone : work_ff.zone;
               rsp_ff.from_window <= work_ff.from_window;
            end
         end
         default: begin
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("item taken while busy");
   a_rsp_after_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_OUT)
      else $error("response without finish");
   a_hit_no_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CTR && cls.hit && !bad_ff) |=> !work_ff.from_window)
      else $error("window flag on direct hit");
`endif

endmodule
`default_nettype wire
